// ----- sv/sem_pkg.sv -----
// Shared types and constants for the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  localparam logic [15:0] GRAY_RED   = 16'd77;
  localparam logic [15:0] GRAY_GREEN = 16'd150;
  localparam logic [15:0] GRAY_BLUE  = 16'd29;

  localparam logic [7:0] EDGE_MAX = 8'd255;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COLOR_MODE   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
    logic        color_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  edge_value;
    logic [10:0] out_column;
    logic [15:0] out_row;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0]  top;
    logic [7:0]  mid;
    logic [7:0]  bot;
    logic        emit;
    logic [10:0] column;
    logic [15:0] row;
    logic        last;
  } item_t;

endpackage

// ----- sv/sem_fifo.sv -----
// Small show-ahead queue with a fill level output.
`timescale 1ns / 1ps

module sem_fifo #(
  parameter type data_t = logic,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  data_t         wdata,
  input  logic          pop,
  output data_t         rdata,
  output logic          empty,
  output logic [LW-1:0] level
);

  data_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (level == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop && !empty) begin
        rd_ptr <= bump(rd_ptr);
      end
      level <= level + LW'(push) - LW'(pop && !empty);
    end
  end

endmodule

// ----- sv/sem_front.sv -----
// Front end: gray conversion, raster counters, line stores and classification.
`timescale 1ns / 1ps

module sem_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int DEPTH = 4,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int EW = (CW + 1 > 12) ? CW + 1 : 12,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  sem_pkg::cfg_t   cfg,
  input  logic            push,
  output logic            full,
  input  sem_pkg::pixel_t pixel,
  input  logic [LW-1:0]   q_level,
  output logic            item_valid,
  output sem_pkg::item_t  item
);

  import sem_pkg::*;

  logic [7:0] line_above [MAX_WIDTH];
  logic [7:0] line_two_above [MAX_WIDTH];

  logic [CW-1:0] column_count;
  logic [CW-1:0] column_count_next;
  logic [15:0]   row_count;
  logic [15:0]   row_count_next;

  logic [7:0] rd_above;
  logic [7:0] rd_two;

  logic          f1_valid;
  logic [7:0]    f1_gray;
  logic [CW-1:0] f1_idx;
  logic          f1_emit;
  logic [10:0]   f1_col;
  logic [15:0]   f1_row;
  logic          f1_last;

  logic          fwd_valid;
  logic [CW-1:0] fwd_idx;
  logic [7:0]    fwd_top;
  logic [7:0]    fwd_mid;

  logic          accept;
  logic [15:0]   gray_sum;
  logic [7:0]    gray;
  logic [EW-1:0] width_ext;
  logic [EW-1:0] w_eff;
  logic [EW-1:0] col_plus;
  logic [16:0]   row_plus;
  logic          row_end;
  logic          frame_end;
  logic          emit;
  logic [CW-1:0] col_m1;
  logic          fwd_hit;
  logic [7:0]    top;
  logic [7:0]    mid;

  assign full = ({1'b0, q_level} + (LW + 1)'(f1_valid)) >= (LW + 1)'(DEPTH);
  assign accept = push && !full;

  assign gray_sum = GRAY_RED * 16'(pixel.red) + GRAY_GREEN * 16'(pixel.green)
                  + GRAY_BLUE * 16'(pixel.blue);
  assign gray = cfg.color_mode ? gray_sum[15:8] : pixel.red;

  assign width_ext = EW'(cfg.image_width);
  assign w_eff     = (width_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : width_ext;
  assign col_plus  = EW'(column_count) + 1'b1;
  assign row_plus  = 17'(row_count) + 1'b1;
  assign row_end   = col_plus >= w_eff;
  assign frame_end = row_plus >= 17'(cfg.image_height);

  assign emit = (w_eff >= EW'(3)) && (cfg.image_height >= 16'd3)
             && (column_count >= CW'(2)) && (row_count >= 16'd2);
  assign col_m1 = column_count - 1'b1;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = frame_end ? '0 : row_plus[15:0];
    end else begin
      column_count_next = col_plus[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_above <= line_above[column_count];
      rd_two   <= line_two_above[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_gray <= gray;
      f1_idx  <= column_count;
      f1_emit <= emit;
      f1_col  <= 11'(col_m1);
      f1_row  <= row_count - 1'b1;
      f1_last <= row_end && frame_end;
    end
  end

  assign fwd_hit = fwd_valid && (fwd_idx == f1_idx);
  assign top = fwd_hit ? fwd_top : rd_two;
  assign mid = fwd_hit ? fwd_mid : rd_above;

  always_ff @(posedge clk) begin
    if (f1_valid) begin
      line_two_above[f1_idx] <= mid;
      line_above[f1_idx]     <= f1_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_valid) begin
      fwd_idx <= f1_idx;
      fwd_top <= mid;
      fwd_mid <= f1_gray;
    end
  end

  assign item_valid  = f1_valid;
  assign item.top    = top;
  assign item.mid    = mid;
  assign item.bot    = f1_gray;
  assign item.emit   = f1_emit;
  assign item.column = f1_col;
  assign item.row    = f1_row;
  assign item.last   = f1_last;

endmodule

// ----- sv/sem_back.sv -----
// Back end: 3x3 window, Sobel gradients and magnitude.
`timescale 1ns / 1ps

module sem_back #(
  parameter int DEPTH = 4,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  sem_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic [LW-1:0]    out_level,
  output logic             out_push,
  output sem_pkg::result_t out_data
);

  import sem_pkg::*;

  logic [7:0] window_pixels [6];

  logic        b1_valid;
  logic [9:0]  b1_gx;
  logic [9:0]  b1_gy;
  logic [10:0] b1_col;
  logic [15:0] b1_row;
  logic        b1_last;

  logic [9:0]  sx_hi;
  logic [9:0]  sx_lo;
  logic [9:0]  sy_hi;
  logic [9:0]  sy_lo;
  logic [9:0]  gx;
  logic [9:0]  gy;
  logic [10:0] grad_sum;
  logic [8:0]  mag;

  function automatic logic [9:0] tap_sum(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
    return 10'(a) + {1'b0, b, 1'b0} + 10'(c);
  endfunction

  assign q_pop = !q_empty
              && (({1'b0, out_level} + (LW + 1)'(b1_valid)) < (LW + 1)'(DEPTH));

  assign sx_hi = tap_sum(q_item.top, q_item.mid, q_item.bot);
  assign sx_lo = tap_sum(window_pixels[0], window_pixels[1], window_pixels[2]);
  assign sy_hi = tap_sum(window_pixels[2], window_pixels[5], q_item.bot);
  assign sy_lo = tap_sum(window_pixels[0], window_pixels[3], q_item.top);
  assign gx = (sx_hi >= sx_lo) ? sx_hi - sx_lo : sx_lo - sx_hi;
  assign gy = (sy_hi >= sy_lo) ? sy_hi - sy_lo : sy_lo - sy_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window_pixels[i] <= '0;
      end
    end else if (q_pop) begin
      window_pixels[0] <= window_pixels[3];
      window_pixels[1] <= window_pixels[4];
      window_pixels[2] <= window_pixels[5];
      window_pixels[3] <= q_item.top;
      window_pixels[4] <= q_item.mid;
      window_pixels[5] <= q_item.bot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= q_pop && q_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_gx   <= gx;
      b1_gy   <= gy;
      b1_col  <= q_item.column;
      b1_row  <= q_item.row;
      b1_last <= q_item.last;
    end
  end

  assign grad_sum = 11'(b1_gx) + 11'(b1_gy);
  assign mag = grad_sum[10:2];

  assign out_push            = b1_valid;
  assign out_data.edge_value = mag[8] ? EDGE_MAX : mag[7:0];
  assign out_data.out_column = b1_col;
  assign out_data.out_row    = b1_row;
  assign out_data.last       = b1_last;

endmodule

// ----- sv/sobel_edge_magnitude_top.sv -----
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
//   port group                      dir   kind
//   push / full / pixel             in    pixel queue, raster order
//   empty / pop / result            out   result queue, interior pixels only
//   cfg_valid / cfg_ready / cfg_*   in    register writes, always ready
//
// One pixel per clock while full is low; a result reaches the result ports through
// the line store read, the middle queue, the gradient register and the result queue.
// The line store read-modify-write loop sets the pixel rate.
// Reset clears counters, window and queues; line stores hold no reset value.
// full rises when the middle queue and the line store stage hold four items;
// the back end pauses when the result queue and its gradient stage hold four.
`timescale 1ns / 1ps

module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT,
  parameter int DEPTH = sem_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  sem_pkg::pixel_t  pixel,
  output logic             empty,
  input  logic             pop,
  output sem_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  import sem_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);

  cfg_t cfg;

  logic          item_valid;
  item_t         item;
  item_t         q_item;
  logic          q_empty;
  logic          q_pop;
  logic [LW-1:0] q_level;
  logic          out_push;
  result_t       out_data;
  logic [LW-1:0] out_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
      cfg.color_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        REG_COLOR_MODE:   cfg.color_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sem_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .DEPTH(DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .push(push),
    .full(full),
    .pixel(pixel),
    .q_level(q_level),
    .item_valid(item_valid),
    .item(item)
  );

  sem_fifo #(
    .data_t(item_t),
    .DEPTH(DEPTH)
  ) u_mid_queue (
    .clk(clk),
    .rst(rst),
    .push(item_valid),
    .wdata(item),
    .pop(q_pop),
    .rdata(q_item),
    .empty(q_empty),
    .level(q_level)
  );

  sem_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_item(q_item),
    .q_pop(q_pop),
    .out_level(out_level),
    .out_push(out_push),
    .out_data(out_data)
  );

  sem_fifo #(
    .data_t(result_t),
    .DEPTH(DEPTH)
  ) u_out_queue (
    .clk(clk),
    .rst(rst),
    .push(out_push),
    .wdata(out_data),
    .pop(pop),
    .rdata(result),
    .empty(empty),
    .level(out_level)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench: Sobel edge results predicted per pixel and compared in order.
`timescale 1ns / 1ps

module testbench;
  import sem_pkg::*;

  localparam int MAX_W      = MAX_WIDTH_DEFAULT;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 8;
  localparam int RANDOM_PIX = 380;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  pixel_t     pixel;
  logic       empty;
  logic       pop;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  reg_index_t cfg_index;
  logic [15:0] cfg_data;

  sobel_edge_magnitude_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic [11:0] img_width  = WIDTH_RESET;
  logic [15:0] img_height = HEIGHT_RESET;
  bit          img_color  = 1'b0;
  bit [7:0]    line_prev  [MAX_W];
  bit [7:0]    line_prev2 [MAX_W];
  bit [7:0]    win [6];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  result_t     pending_edges [$];
  int          errors = 0;
  int unsigned pixels_sent = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic sobel_predict(input pixel_t p);
    int unsigned w, c, r, rr, gg, bb, gray, top, mid, bot, idx, gx, gy, mag;
    result_t res;
    w = (img_width > MAX_W) ? MAX_W : img_width;
    c = col_pos;
    r = row_pos;
    rr = p.red;
    gg = p.green;
    bb = p.blue;
    if (img_color) begin
      gray = ((GRAY_RED * rr + GRAY_GREEN * gg + GRAY_BLUE * bb) >> 8) & 32'hFF;
    end else begin
      gray = rr;
    end
    idx = (c < MAX_W) ? c : MAX_W - 1;
    top = line_prev2[idx];
    mid = line_prev[idx];
    bot = gray;
    if (w >= 3 && img_height >= 3 && c >= 2 && r >= 2) begin
      gx = abs_diff(top + 2 * mid + bot, win[0] + 2 * win[1] + win[2]);
      gy = abs_diff(win[2] + 2 * win[5] + bot, win[0] + 2 * win[3] + top);
      mag = (gx + gy) / 4;
      if (mag > EDGE_MAX) mag = EDGE_MAX;
      res.edge_value = 8'(mag);
      res.out_column = 11'(c - 1);
      res.out_row    = 16'(r - 1);
      res.last       = (c + 1 >= w) && (r + 1 >= img_height);
      pending_edges.push_back(res);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = 8'(top);
    win[4] = 8'(mid);
    win[5] = 8'(bot);
    line_prev2[idx] = 8'(mid);
    line_prev[idx]  = 8'(gray);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= img_height) ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic logic [7:0] rand_sample();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red   = rand_sample();
    p.green = rand_sample();
    p.blue  = rand_sample();
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_sent++;
    sobel_predict(p);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val, input bit final_one);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  img_width  = val[11:0];
      REG_IMAGE_HEIGHT: img_height = val;
      REG_COLOR_MODE:   img_color  = val[0];
      default: ;
    endcase
    if (final_one) cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h, input logic [15:0] c);
    drain();
    write_reg(REG_IMAGE_WIDTH, w, 1'b0);
    write_reg(REG_IMAGE_HEIGHT, h, 1'b0);
    write_reg(REG_COLOR_MODE, c, 1'b1);
  endtask

  task automatic send_frame(input int unsigned count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  // results checked in arrival order
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_edges.size() == 0) begin
          $error("result with no request pending: column %0d row %0d",
                 result.out_column, result.out_row);
          errors++;
        end else begin
          result_t exp_r;
          exp_r = pending_edges.pop_front();
          if (result.edge_value !== exp_r.edge_value) begin
            $error("edge_value: expected %0d, got %0d", exp_r.edge_value, result.edge_value);
            errors++;
          end
          if (result.out_column !== exp_r.out_column) begin
            $error("out_column: expected %0d, got %0d", exp_r.out_column, result.out_column);
            errors++;
          end
          if (result.out_row !== exp_r.out_row) begin
            $error("out_row: expected %0d, got %0d", exp_r.out_row, result.out_row);
            errors++;
          end
          if (result.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, result.last);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // cross the default row end, then narrow the frame to reach an interior pixel
  task automatic test_reset_defaults();
    send_frame(WIDTH_RESET + 1);
    drain();
    write_reg(REG_IMAGE_WIDTH, 16'd3, 1'b1);
    send_frame(5);
  endtask

  // shrink height with the row counter past the new bound
  task automatic test_midframe_wrap();
    drain();
    write_reg(REG_IMAGE_HEIGHT, 16'd3, 1'b1);
    send_frame(img_width);
  endtask

  // run a short row at the widest width, then narrow it past the column counter
  task automatic test_widest_frame();
    set_frame(16'h0FFF, 16'd3, 16'd1);
    send_frame(24);
    drain();
    write_reg(REG_IMAGE_WIDTH, 16'd3, 1'b1);
    while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel());
  endtask

  task automatic test_saturation();
    pixel_t p;
    set_frame(16'd3, 16'd3, 16'd0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p = rand_pixel();
        p.red = (r > 0 && c > 0) ? 8'hFF : 8'h00;
        send_pixel(p);
      end
    end
  endtask

  task automatic test_color_extremes();
    pixel_t p;
    set_frame(16'd3, 16'd3, 16'd1);
    for (int i = 0; i < 9; i++) begin
      p.red   = {8{i[0]}};
      p.green = {8{i[1]}};
      p.blue  = {8{i[2]}};
      send_pixel(p);
    end
  endtask

  task automatic test_small_images();
    set_frame(16'd2, 16'd2, 16'd0);
    send_frame(4);
    set_frame(16'd4, 16'd1, 16'd1);
    send_frame(4);
    set_frame(16'd0, 16'd0, 16'd0);
    send_frame(2);
  endtask

  task automatic test_tall_frame();
    set_frame(16'd3, 16'hFFFF, 16'd0);
    send_frame(15);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 16'd2, 1'b1);
    send_frame(3);
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, kind, part;
    reg_index_t idx;
    logic [15:0] val;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIX) begin
      idle_on = (pixels_sent - start < RANDOM_PIX * 4 / 5) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 6);
        set_frame(16'(w), 16'(h), 16'($urandom_range(0, 1)));
        send_frame(w * h);
      end else if (kind == 7) begin
        if ($urandom_range(0, 1)) begin
          w = $urandom_range(0, 2);
          h = $urandom_range(0, 8);
        end else begin
          w = $urandom_range(0, 12);
          h = $urandom_range(0, 2);
        end
        set_frame(16'(w), 16'(h), 16'($urandom_range(0, 1)));
        send_frame(((w == 0) ? 1 : w) * ((h == 0) ? 1 : h));
      end else begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 8);
        set_frame(16'(w), 16'(h), 16'($urandom_range(0, 1)));
        part = $urandom_range(0, w * h - 1);
        send_frame(part);
        drain();
        case ($urandom_range(0, 2))
          0: begin
            idx = REG_IMAGE_WIDTH;
            val = 16'(($urandom_range(0, 15) << 12) | $urandom_range(0, 14));
          end
          1: begin
            idx = REG_IMAGE_HEIGHT;
            val = 16'($urandom_range(0, 8));
          end
          default: begin
            idx = REG_COLOR_MODE;
            val = 16'($urandom);
          end
        endcase
        write_reg(idx, val, 1'b1);
        // finish the broken frame so the next one starts at the origin
        while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel());
      end
    end
    idle_on = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    pixel     = '0;
    pop       = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_midframe_wrap();
    test_widest_frame();
    test_saturation();
    test_color_extremes();
    test_small_images();
    test_tall_frame();
    test_random_frames();
    drain();
    if (errors == 0 && pending_edges.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
